/* hw/rtl/block_average_density_grid_macros.svh */
// Assertion macros for the block-average density grid.
// Uses clk and arst_n of the module that includes it.
`ifndef BLOCK_AVERAGE_DENSITY_GRID_MACROS_SVH
`define BLOCK_AVERAGE_DENSITY_GRID_MACROS_SVH

// same-cycle implication
`define BADG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("badg check failed");

// next-cycle implication
`define BADG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("badg check failed");

`endif

/* hw/rtl/badg_pkg.sv */
// Shared types, constants and helpers of the block-average density grid.
// No dependencies.
package badg_pkg;

	localparam int MAX_COLUMNS = 4096;
	localparam int MAX_BLOCK   = 64;
	localparam int MAX_LINES   = 4096;
	localparam int SUM_W       = 22;
	localparam int COL_AW      = $clog2(MAX_COLUMNS);
	localparam int DENS_W      = 16;
	localparam int CFG_W       = 13;

	typedef enum logic [1:0] {
		CFG_BLOCK_SIZE   = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2,
		CFG_COLOUR_MODE  = 2'd3
	} badg_cfg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} badg_div_stat_t;

	typedef struct packed {
		logic [11:0] grid_row;
		logic [11:0] grid_col;
		logic        last_cell;
	} badg_cell_meta_t;

	function automatic logic [6:0] clamp_block(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (v == 7'd0) r = 7'd1;
		else if (v > 7'(MAX_BLOCK)) r = 7'(MAX_BLOCK);
		return r;
	endfunction

	function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] hi);
		logic [12:0] r;
		r = v;
		if (v == 13'd0) r = 13'd1;
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

/* hw/rtl/badg_if.sv */
// Stream interfaces of the block-average density grid: pixels in, cells out.
// Depends on nothing.
interface badg_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface badg_cell_if;
	logic        valid;
	logic        ready;
	logic [11:0] grid_row;
	logic [11:0] grid_col;
	logic [15:0] density;
	logic        last_cell;

	modport source (output valid, output grid_row, output grid_col, output density,
		output last_cell, input ready);
	modport sink (input valid, input grid_row, input grid_col, input density,
		input last_cell, output ready);
endinterface

/* hw/rtl/badg_density_div.sv */
// Radix-2 restoring divider: floor(gap * 65535 / full), one quotient bit per cycle.
// Depends on badg_pkg.
module badg_density_div
	import badg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SUM_W-1:0]     gap,
	input  logic [SUM_W-1:0]     full,
	input  logic                 take,
	output badg_div_stat_t       stat,
	output logic [DENS_W-1:0]    density
);

	typedef enum logic [2:0] {
		DIV_IDLE = 3'b001,
		DIV_RUN  = 3'b010,
		DIV_DONE = 3'b100
	} div_state_t;

	localparam int NUM_W = SUM_W + DENS_W;

	div_state_t          state_q;
	logic [3:0]          cnt_q;
	logic [SUM_W-1:0]    rem_q;
	logic [DENS_W-1:0]   low_q;
	logic [DENS_W-1:0]   quo_q;
	logic [SUM_W-1:0]    full_q;
	logic [NUM_W-1:0]    num;
	logic [SUM_W:0]      trial;
	logic                fits;

	assign num   = {gap, {DENS_W{1'b0}}} - NUM_W'(gap);
	assign trial = {rem_q, low_q[DENS_W-1]};
	assign fits  = trial >= {1'b0, full_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (start) begin
						state_q <= DIV_RUN;
						cnt_q   <= '0;
					end
				end
				DIV_RUN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= DIV_DONE;
				end
				DIV_DONE: begin
					if (take) state_q <= DIV_IDLE;
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			rem_q  <= num[NUM_W-1:DENS_W];
			low_q  <= num[DENS_W-1:0];
			full_q <= full;
			quo_q  <= '0;
		end else if (state_q == DIV_RUN) begin
			rem_q <= fits ? SUM_W'(trial - {1'b0, full_q}) : trial[SUM_W-1:0];
			low_q <= {low_q[DENS_W-2:0], 1'b0};
			quo_q <= {quo_q[DENS_W-2:0], fits};
		end
	end

	assign stat.busy = (state_q != DIV_IDLE);
	assign stat.done = (state_q == DIV_DONE);
	assign density   = quo_q;

endmodule

/* hw/rtl/block_average_density_grid.sv */
// Block-average density grid: top level. Depends on badg_pkg, badg_if,
// badg_density_div and block_average_density_grid_macros.svh.
// Pixels enter in raster order on pix, one transaction per pixel; each
// complete block_size x block_size block yields one cell transaction on grid_cell
// with its grid row, column, Q0.16 density and a last-cell flag.
// Per-column block sums live in a 4096 x 22 synchronous RAM, read at pixel
// accept and written back from stage 1, with a bypass of the last write.
// Throughput: one pixel per cycle while pix.ready is high. The bottom-right pixel
// of a block holds pix.ready low while the divider runs and until its result
// is taken into the output register, where the cell then appears.
// A finished cell waits in the output register while further pixels are
// taken; a second finished block stalls pix until grid_cell.ready takes the first.
// Reset restores block_size 8, 1024 x 1024, gray mode and the frame origin.
// Any cfg_we write restarts the frame; the RAM keeps its contents and needs
// no clearing pass, since each block writes its entry on its first pixel.
`include "block_average_density_grid_macros.svh"

module block_average_density_grid
	import badg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	badg_pix_if.sink           pix,
	badg_cell_if.source        grid_cell,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	logic [6:0]          block_size_q;
	logic [12:0]         image_width_q;
	logic [12:0]         image_height_q;
	logic                colour_mode_q;

	logic [6:0]          s_eff;
	logic [12:0]         w_eff;
	logic [12:0]         h_eff;
	logic [12:0]         ss;
	logic [20:0]         ss255;
	logic [SUM_W-1:0]    full_q;

	logic [11:0]         x_q, y_q;
	logic [5:0]          ox_q, oy_q;
	logic [11:0]         gc_q, gr_q;
	logic [12:0]         bx_q, by_q;

	logic                accept;
	logic                in_grid;
	logic                first_px;
	logic                last_px;
	logic                last_cell;
	logic [5:0]          s_m1;
	logic [9:0]          pix_sum;

	logic                vld_s1;
	logic                grid_s1;
	logic                first_s1;
	logic                emit_s1;
	logic [COL_AW-1:0]   gc_s1;
	logic [9:0]          v_s1;
	badg_cell_meta_t     meta_s1;
	logic [SUM_W-1:0]    rd_s1;

	logic [SUM_W-1:0]    sums_mem [MAX_COLUMNS];
	logic                fwd_vld_q;
	logic [COL_AW-1:0]   fwd_addr_q;
	logic [SUM_W-1:0]    fwd_data_q;
	logic [SUM_W-1:0]    old_sum;
	logic [SUM_W-1:0]    new_sum;
	logic                wr_en;

	logic                div_start;
	logic [SUM_W-1:0]    gap;
	badg_div_stat_t      div_stat;
	logic [DENS_W-1:0]   div_density;
	logic                div_take;
	badg_cell_meta_t     meta_q;

	logic                cell_vld_q;
	badg_cell_meta_t     cell_meta_q;
	logic [DENS_W-1:0]   cell_dens_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= 7'd8;
			image_width_q  <= 13'd1024;
			image_height_q <= 13'd1024;
			colour_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_SIZE:   block_size_q   <= cfg_data[6:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				CFG_COLOUR_MODE:  colour_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_eff = clamp_block(block_size_q);
	assign w_eff = clamp_dim(image_width_q, 13'(MAX_COLUMNS));
	assign h_eff = clamp_dim(image_height_q, 13'(MAX_LINES));
	assign ss    = 13'(s_eff) * 13'(s_eff);
	assign ss255 = {ss, 8'd0} - 21'(ss);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= SUM_W'(16320);
		else full_q <= colour_mode_q ? (SUM_W'(ss255) + SUM_W'({ss255, 1'b0}))
			: SUM_W'(ss255);
	end

	// raster position
	assign accept    = pix.valid && pix.ready;
	assign s_m1      = 6'(s_eff - 7'd1);
	assign in_grid   = (14'(bx_q) + 14'(s_eff) <= 14'(w_eff))
		&& (14'(by_q) + 14'(s_eff) <= 14'(h_eff));
	assign first_px  = (ox_q == 6'd0) && (oy_q == 6'd0);
	assign last_px   = (ox_q == s_m1) && (oy_q == s_m1);
	assign last_cell = (14'(bx_q) + 14'({s_eff, 1'b0}) > 14'(w_eff))
		&& (14'(by_q) + 14'({s_eff, 1'b0}) > 14'(h_eff));
	assign pix_sum   = colour_mode_q ? (10'(pix.red) + 10'(pix.green) + 10'(pix.blue))
		: 10'(pix.red);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0; y_q  <= '0;
			ox_q <= '0; oy_q <= '0;
			gc_q <= '0; gr_q <= '0;
			bx_q <= '0; by_q <= '0;
		end else if (cfg_we) begin
			x_q  <= '0; y_q  <= '0;
			ox_q <= '0; oy_q <= '0;
			gc_q <= '0; gr_q <= '0;
			bx_q <= '0; by_q <= '0;
		end else if (accept) begin
			if (13'(x_q) + 13'd1 >= w_eff) begin
				x_q  <= '0;
				ox_q <= '0;
				gc_q <= '0;
				bx_q <= '0;
				if (13'(y_q) + 13'd1 >= h_eff) begin
					y_q  <= '0;
					oy_q <= '0;
					gr_q <= '0;
					by_q <= '0;
				end else begin
					y_q <= y_q + 12'd1;
					if (7'(oy_q) + 7'd1 >= s_eff) begin
						oy_q <= '0;
						gr_q <= gr_q + 12'd1;
						by_q <= by_q + 13'(s_eff);
					end else begin
						oy_q <= oy_q + 6'd1;
					end
				end
			end else begin
				x_q <= x_q + 12'd1;
				if (7'(ox_q) + 7'd1 >= s_eff) begin
					ox_q <= '0;
					gc_q <= gc_q + 12'd1;
					bx_q <= bx_q + 13'(s_eff);
				end else begin
					ox_q <= ox_q + 6'd1;
				end
			end
		end
	end

	// stage 1: read-modify-write of the column sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grid_s1           <= in_grid;
			first_s1          <= first_px;
			emit_s1           <= in_grid && last_px;
			gc_s1             <= COL_AW'(gc_q);
			v_s1              <= pix_sum;
			meta_s1.grid_row  <= gr_q;
			meta_s1.grid_col  <= gc_q;
			meta_s1.last_cell <= last_cell;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) sums_mem[gc_s1] <= new_sum;
		if (accept) rd_s1 <= sums_mem[COL_AW'(gc_q)];
	end

	assign old_sum = (fwd_vld_q && fwd_addr_q == gc_s1) ? fwd_data_q : rd_s1;
	assign new_sum = first_s1 ? SUM_W'(v_s1) : old_sum + SUM_W'(v_s1);
	assign wr_en   = vld_s1 && grid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_vld_q <= 1'b0;
		else if (wr_en) fwd_vld_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= gc_s1;
			fwd_data_q <= new_sum;
		end
	end

	// density division
	assign div_start = vld_s1 && emit_s1;
	assign gap       = (new_sum > full_q) ? '0 : full_q - new_sum;

	badg_density_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.gap     (gap),
		.full    (full_q),
		.take    (div_take),
		.stat    (div_stat),
		.density (div_density)
	);

	always_ff @(posedge clk) begin
		if (div_start) meta_q <= meta_s1;
	end

	// output register
	assign div_take = div_stat.done && (!cell_vld_q || grid_cell.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cell_vld_q <= 1'b0;
		else if (div_take) cell_vld_q <= 1'b1;
		else if (grid_cell.ready) cell_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (div_take) begin
			cell_meta_q <= meta_q;
			cell_dens_q <= div_density;
		end
	end

	assign pix.ready           = !div_stat.busy && !(vld_s1 && emit_s1);
	assign grid_cell.valid     = cell_vld_q;
	assign grid_cell.grid_row  = cell_meta_q.grid_row;
	assign grid_cell.grid_col  = cell_meta_q.grid_col;
	assign grid_cell.density   = cell_dens_q;
	assign grid_cell.last_cell = cell_meta_q.last_cell;

	`BADG_ASSERT_IMP(a_no_accept_on_emit, vld_s1 && emit_s1, !pix.ready)
	`BADG_ASSERT_IMP(a_start_when_idle, div_start, !div_stat.busy)
	`BADG_ASSERT_NXT(a_busy_after_start, div_start, div_stat.busy)
	`BADG_ASSERT_IMP(a_offset_in_block, 1'b1, (7'(ox_q) < s_eff) && (7'(oy_q) < s_eff))

endmodule

/* dv/tb_block_average_density_grid.sv */
// Self-checking testbench for block_average_density_grid: drives raster pixel frames,
// predicts each grid cell's row, column, density and last flag, and checks every cell.
// Depends on badg_pkg, badg_if and the block_average_density_grid RTL.
module tb_block_average_density_grid
	import badg_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_DIR = 39;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_PIXELS = 80;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic [15:0] dens;
		logic        last;
	} cell_exp_t;

	typedef enum logic [1:0] {STEP_PIXEL, STEP_PIXEL_KNOWN, STEP_WRITE} step_kind_t;
	typedef enum logic [1:0] {FRAME_RANDOM, FRAME_HOLD, FRAME_MAX} frame_kind_t;

	typedef struct packed {
		step_kind_t    kind;
		badg_cfg_idx_t idx;
		logic [12:0]   val;
		logic [7:0]    r;
		logic [7:0]    g;
		logic [7:0]    b;
		cell_exp_t     want;
	} dir_step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	badg_pix_if pix_bus();
	badg_cell_if cell_bus();

	block_average_density_grid dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_bus),
		.grid_cell(cell_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// grid state as seen by the predictor
	logic [6:0]  cur_block = 7'd8;
	logic [12:0] cur_width = 13'd1024;
	logic [12:0] cur_height = 13'd1024;
	bit          cur_colour = 1'b0;
	logic [SUM_W-1:0] col_acc [MAX_COLUMNS];
	int unsigned pos_x = 0, pos_y = 0, sub_x = 0, sub_y = 0;

	cell_exp_t pending_cells[$];
	int mismatch_count = 0;
	int src_idle = 0;
	int snk_stall = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	dir_step_t dir_steps [N_DIR] = '{
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'hFF, 8'hFF, 8'hFF, '0},
		'{STEP_WRITE, CFG_BLOCK_SIZE, 13'd1, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_WRITE, CFG_IMAGE_WIDTH, 13'd2, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd2, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_PIXEL_KNOWN, CFG_BLOCK_SIZE, 13'd0, 8'h00, 8'hFF, 8'hFF,
			'{12'd0, 12'd0, 16'd65535, 1'b0}},
		'{STEP_PIXEL_KNOWN, CFG_BLOCK_SIZE, 13'd0, 8'hFF, 8'h00, 8'h00,
			'{12'd0, 12'd1, 16'd0, 1'b0}},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'hAA, 8'h55, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h55, 8'hAA, 8'hFF, '0},
		'{STEP_WRITE, CFG_COLOUR_MODE, 13'd1, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_PIXEL_KNOWN, CFG_BLOCK_SIZE, 13'd0, 8'hFF, 8'hFF, 8'hFF,
			'{12'd0, 12'd0, 16'd0, 1'b0}},
		'{STEP_PIXEL_KNOWN, CFG_BLOCK_SIZE, 13'd0, 8'h00, 8'h00, 8'h00,
			'{12'd0, 12'd1, 16'd65535, 1'b0}},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h80, 8'h7F, 8'h01, '0},
		'{STEP_PIXEL_KNOWN, CFG_BLOCK_SIZE, 13'd0, 8'h00, 8'h00, 8'h00,
			'{12'd1, 12'd1, 16'd65535, 1'b1}},
		'{STEP_WRITE, CFG_IMAGE_WIDTH, 13'd0, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd0, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_PIXEL_KNOWN, CFG_BLOCK_SIZE, 13'd0, 8'hFF, 8'hFF, 8'hFF,
			'{12'd0, 12'd0, 16'd0, 1'b1}},
		'{STEP_PIXEL_KNOWN, CFG_BLOCK_SIZE, 13'd0, 8'h00, 8'h00, 8'h00,
			'{12'd0, 12'd0, 16'd65535, 1'b1}},
		'{STEP_WRITE, CFG_BLOCK_SIZE, 13'd0, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_PIXEL_KNOWN, CFG_BLOCK_SIZE, 13'd0, 8'hFF, 8'h00, 8'hFF,
			'{12'd0, 12'd0, 16'd21845, 1'b1}},
		'{STEP_WRITE, CFG_BLOCK_SIZE, 13'd127, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_WRITE, CFG_IMAGE_WIDTH, 13'd3, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd2, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h12, 8'h34, 8'h56, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'hFF, 8'hFF, 8'hFF, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h01, 8'h02, 8'h04, '0},
		'{STEP_WRITE, CFG_BLOCK_SIZE, 13'd2, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_WRITE, CFG_IMAGE_WIDTH, 13'd3, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_WRITE, CFG_IMAGE_HEIGHT, 13'd3, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_WRITE, CFG_COLOUR_MODE, 13'd0, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h10, 8'h20, 8'h40, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'hFF, 8'h80, 8'h01, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h08, 8'h00, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h00, 8'hFF, 8'hFF, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'hFE, 8'h00, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h7F, 8'h00, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'hFF, 8'h00, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'h00, 8'h00, 8'h00, '0},
		'{STEP_PIXEL, CFG_BLOCK_SIZE, 13'd0, 8'hC3, 8'h3C, 8'h99, '0}
	};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit predict_cell(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, output cell_exp_t c);
		int unsigned s, w, h, cols, rows, gc, gr, v;
		longint unsigned full, acc, dens;
		bit hit;
		hit = 1'b0;
		c = '0;
		s = (cur_block == 0) ? 1 : ((cur_block > MAX_BLOCK) ? MAX_BLOCK : cur_block);
		w = (cur_width == 0) ? 1 : ((cur_width > MAX_COLUMNS) ? MAX_COLUMNS : cur_width);
		h = (cur_height == 0) ? 1 : ((cur_height > MAX_LINES) ? MAX_LINES : cur_height);
		cols = w / s;
		rows = h / s;
		gc = pos_x / s;
		gr = pos_y / s;
		v = r;
		if (cur_colour)
			v = v + g + b;
		if (gc < cols && gr < rows) begin
			if (sub_x == 0 && sub_y == 0)
				col_acc[gc] = SUM_W'(v);
			else
				col_acc[gc] = col_acc[gc] + SUM_W'(v);
			if (sub_x == s - 1 && sub_y == s - 1) begin
				full = longint'(s) * s * 255 * (cur_colour ? 3 : 1);
				acc = col_acc[gc];
				dens = (acc <= full) ? ((full - acc) * 65535) / full : 0;
				c.row = 12'(gr);
				c.col = 12'(gc);
				c.dens = 16'(dens);
				c.last = (gr == rows - 1 && gc == cols - 1);
				hit = 1'b1;
			end
		end
		// advance raster position
		if (pos_x + 1 >= w) begin
			pos_x = 0;
			sub_x = 0;
			if (pos_y + 1 >= h) begin
				pos_y = 0;
				sub_y = 0;
			end else begin
				pos_y = pos_y + 1;
				sub_y = (sub_y + 1 >= s) ? 0 : sub_y + 1;
			end
		end else begin
			pos_x = pos_x + 1;
			sub_x = (sub_x + 1 >= s) ? 0 : sub_x + 1;
		end
		return hit;
	endfunction

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input bit known, input cell_exp_t want);
		cell_exp_t c;
		bit got;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.red <= r;
		pix_bus.green <= g;
		pix_bus.blue <= b;
		@(posedge clk);
		while (!pix_bus.ready)
			@(posedge clk);
		got = predict_cell(r, g, b, c);
		if (known)
			pending_cells.push_back(want);
		else if (got)
			pending_cells.push_back(c);
	endtask

	task automatic wait_cells_drained();
		@(negedge clk);
		pix_bus.valid <= 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input badg_cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BLOCK_SIZE: cur_block = val[6:0];
			CFG_IMAGE_WIDTH: cur_width = val;
			CFG_IMAGE_HEIGHT: cur_height = val;
			CFG_COLOUR_MODE: cur_colour = val[0];
			default: ;
		endcase
		pos_x = 0;
		pos_y = 0;
		sub_x = 0;
		sub_y = 0;
	endtask

	task automatic run_frame(input frame_kind_t kind, inout int pix_count);
		int sel, blk, s, w, h, count;
		bit colour;
		logic [12:0] blk_val, col_val;
		wait_cells_drained();
		colour = $urandom_range(0, 1);
		case (kind)
			FRAME_HOLD: begin
				blk = 1;
				w = 8;
				h = 4;
				count = w * h;
			end
			FRAME_MAX: begin
				blk = 16;
				w = 16;
				h = 16;
				colour = 1'b1;
				count = w * h;
			end
			default: begin
				sel = $urandom_range(0, 99);
				if (sel < 58) blk = $urandom_range(1, 2);
				else if (sel < 88) blk = $urandom_range(3, 4);
				else if (sel < 94) blk = $urandom_range(5, 8);
				else if (sel < 97) blk = 0;
				else blk = $urandom_range(65, 127);
				s = (blk == 0) ? 1 : ((blk > MAX_BLOCK) ? MAX_BLOCK : blk);
				w = $urandom_range(s, 7 * s - 1);
				h = $urandom_range(s, 5 * s - 1);
				if (w > 40) w = 40;
				if (h > 20) h = 20;
				count = w * h;
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					// wide lines: saturated width, partial frame
					blk = $urandom_range(1, 2);
					w = $urandom_range(MAX_COLUMNS, 8191);
					h = $urandom_range(1, 8191);
					count = $urandom_range(30, 80);
				end else if (sel < 3) begin
					count = $urandom_range(1, w * h);
				end else if (sel < 5) begin
					count = 2 * w * h;
				end
				if (count > 2 * PHASE_PIXELS) count = 2 * PHASE_PIXELS;
			end
		endcase
		blk_val = 13'(blk);
		col_val = 13'(colour);
		if (kind == FRAME_RANDOM && $urandom_range(0, 7) == 0)
			blk_val[12:7] = 6'($urandom_range(1, 63));
		if (kind == FRAME_RANDOM && $urandom_range(0, 7) == 0)
			col_val[12:1] = 12'($urandom_range(1, 4095));
		write_cfg(CFG_BLOCK_SIZE, blk_val);
		write_cfg(CFG_IMAGE_WIDTH, 13'(w));
		write_cfg(CFG_IMAGE_HEIGHT, 13'(h));
		write_cfg(CFG_COLOUR_MODE, col_val);
		if (kind == FRAME_HOLD) begin
			@(posedge clk);
			hold_req = 1'b1;
		end
		for (int i = 0; i < count; i++) begin
			if (kind == FRAME_MAX)
				send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
			else
				send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
		end
		pix_count += count;
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			cell_bus.ready <= 1'b0;
		end else begin
			cell_bus.ready <= ($urandom_range(0, 99) >= snk_stall);
		end
	end

	always @(posedge clk) begin : cell_check
		cell_exp_t want;
		if (arst_n && cell_bus.valid && cell_bus.ready) begin
			if (pending_cells.size() == 0) begin
				$error("unexpected cell transaction: row %0d col %0d density %0d",
					cell_bus.grid_row, cell_bus.grid_col, cell_bus.density);
				mismatch_count++;
			end else begin
				want = pending_cells.pop_front();
				if (cell_bus.grid_row !== want.row) begin
					$error("grid_row: expected %0d, got %0d", want.row, cell_bus.grid_row);
					mismatch_count++;
				end
				if (cell_bus.grid_col !== want.col) begin
					$error("grid_col: expected %0d, got %0d", want.col, cell_bus.grid_col);
					mismatch_count++;
				end
				if (cell_bus.density !== want.dens) begin
					$error("density: expected %0d, got %0d", want.dens, cell_bus.density);
					mismatch_count++;
				end
				if (cell_bus.last_cell !== want.last) begin
					$error("last_cell: expected %0d, got %0d", want.last,
						cell_bus.last_cell);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_bus.valid && pix_bus.ready) || (cell_bus.valid && cell_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int phase_count;
		int src_plan [4];
		int snk_plan [4];
		src_plan = '{0, 73, 0, 8};
		snk_plan = '{0, 0, 73, 8};
		phase_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BLOCK_SIZE;
		cfg_data = '0;
		pix_bus.valid = 1'b0;
		pix_bus.red = 8'h00;
		pix_bus.green = 8'h00;
		pix_bus.blue = 8'h00;
		cell_bus.ready = 1'b0;
		for (int i = 0; i < MAX_COLUMNS; i++)
			col_acc[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_steps[i]) begin
			if (dir_steps[i].kind == STEP_WRITE) begin
				wait_cells_drained();
				write_cfg(dir_steps[i].idx, dir_steps[i].val);
			end else begin
				send_pixel(dir_steps[i].r, dir_steps[i].g, dir_steps[i].b,
					dir_steps[i].kind == STEP_PIXEL_KNOWN, dir_steps[i].want);
			end
		end

		for (int p = 0; p < 4; p++) begin
			src_idle = src_plan[p];
			snk_stall = snk_plan[p];
			phase_count = 0;
			if (p == 0) begin
				run_frame(FRAME_HOLD, phase_count);
				run_frame(FRAME_MAX, phase_count);
				phase_count = 0;
			end
			while (phase_count < PHASE_PIXELS)
				run_frame(FRAME_RANDOM, phase_count);
		end

		wait_cells_drained();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
